/* design/energy_meter_frame_parser_top_defines.svh */
// Assertion macros shared by the frame parser modules.
// Expects clk and rst_n in the scope of each use.
`ifndef ENERGY_METER_FRAME_PARSER_TOP_DEFINES_SVH
`define ENERGY_METER_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define EMFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define EMFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/emfp_pkg.sv */
// Types and constants of the metering reply frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package emfp_pkg;

  localparam int FRAME_BYTES = 23;
  localparam int CAP_DEPTH   = 19;
  localparam int POS_W       = 5;
  localparam int CAP_IDX_W   = 5;

  localparam logic [7:0] READ_CMD_BASE = 8'h58;
  localparam logic [7:0] HEADER_BYTE   = 8'h55;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_HEADER = 2'd1;
  localparam logic [1:0] ERR_CSUM   = 2'd2;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;
  localparam int CMDQ_CNT_W = 2;

  localparam int ENERGY_OUT_W = 48;
  localparam int OUT_DATA_W   = 192;
  localparam int OUT_USER_W   = 3;

  typedef struct packed {
    logic        op;
    logic [1:0]  err;
    logic [23:0] cur;
    logic [23:0] volt;
    logic [23:0] fast;
    logic [23:0] pwr;
    logic [23:0] cnt;
    logic [15:0] freq;
    logic [7:0]  status;
  } emfp_cmd_t;

endpackage

`default_nettype wire

/* design/energy_meter_frame_parser_top.sv */
// Metering reply frame parser, top level: front end, command queue, back end.
// Depends on emfp_pkg, emfp_front, emfp_cmd_fifo and emfp_back.
//
// A user drives one beat per received event: in_tuser is the kind (start of
// frame, received byte, clear energy total) and in_tdata the byte. The block
// takes one beat every cycle while its two-entry command queue has room; the
// checksum byte of a frame and a clear event each occupy one queue entry. The
// back end retires one entry per cycle while its output register is free or
// being read, so the sustained rate is then one beat per cycle; a result beat
// waits there and can stall input once the queue fills. The user writes the
// two-bit device address on the cfg port while idle; the block does not enforce
// it. The energy total is ENERGY_BITS wide and reported in its low 48 bits.
`default_nettype none

module energy_meter_frame_parser_top #(
  parameter int ENERGY_BITS = 48
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [1:0]                       cfg_data,   // device_address
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [7:0]                       in_tdata,   // data_byte
  input  wire  [1:0]                       in_tuser,   // kind
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // current_rms, voltage_rms, current_fast_rms, active_power, pulse_counter,
  // line_frequency, status_bits, energy_pulses
  output logic [emfp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [emfp_pkg::OUT_USER_W-1:0]  out_tuser   // valid_res, error_code
);
  import emfp_pkg::*;

  emfp_cmd_t push_data, pop_data;
  logic      push, full, pop, pop_valid;

  emfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  emfp_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  emfp_back #(
    .ENERGY_BITS (ENERGY_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* design/emfp_front.sv */
// Front end: takes input beats, tracks frame position and checksum, captures
// field bytes and issues frame and clear commands. Depends on emfp_pkg.
`default_nettype none
`include "energy_meter_frame_parser_top_defines.svh"

module emfp_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [1:0]            cfg_data,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [7:0]            in_tdata,
  input  wire  [1:0]            in_tuser,
  input  wire                   q_full,
  output logic                  q_push,
  output emfp_pkg::emfp_cmd_t   q_data
);
  import emfp_pkg::*;

  logic [1:0]       addr_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [7:0]       cap_r [CAP_DEPTH];
  logic             accept;
  logic             cap_we;
  logic [CAP_IDX_W-1:0] cap_idx;
  logic [1:0]       err;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cap_idx   = CAP_IDX_W'(pos_r - POS_W'(1));

  always_comb begin
    if (!hdr_ok_r) begin
      err = ERR_HEADER;
    end else if (~sum_r != in_tdata) begin
      err = ERR_CSUM;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    hdr_ok_nxt = hdr_ok_r;
    cap_we     = 1'b0;
    q_push     = 1'b0;
    if (accept) begin
      case (in_tuser)
        KIND_START: begin
          pos_nxt    = '0;
          sum_nxt    = READ_CMD_BASE | {6'b0, addr_r};
          hdr_ok_nxt = 1'b0;
        end
        KIND_BYTE: begin
          if (pos_r < POS_W'(FRAME_BYTES)) begin
            pos_nxt = pos_r + POS_W'(1);
            if (pos_r < POS_W'(FRAME_BYTES - 1)) begin
              sum_nxt = sum_r + in_tdata;
              if (pos_r == '0) begin
                hdr_ok_nxt = (in_tdata == HEADER_BYTE);
              end else if (pos_r <= POS_W'(CAP_DEPTH)) begin
                cap_we = 1'b1;
              end
            end else begin
              q_push = 1'b1;
            end
          end
        end
        KIND_CLEAR: begin
          q_push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    q_data.op     = (in_tuser == KIND_CLEAR) ? CMD_CLEAR : CMD_FRAME;
    q_data.err    = err;
    q_data.cur    = {cap_r[2], cap_r[1], cap_r[0]};
    q_data.volt   = {cap_r[5], cap_r[4], cap_r[3]};
    q_data.fast   = {cap_r[8], cap_r[7], cap_r[6]};
    q_data.pwr    = {cap_r[11], cap_r[10], cap_r[9]};
    q_data.cnt    = {cap_r[14], cap_r[13], cap_r[12]};
    q_data.freq   = {cap_r[16], cap_r[15]};
    q_data.status = cap_r[18];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      pos_r    <= POS_W'(FRAME_BYTES);
      sum_r    <= '0;
      hdr_ok_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        addr_r <= cfg_data;
      end
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      hdr_ok_r <= hdr_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_r[cap_idx] <= in_tdata;
    end
  end

  `EMFP_ASSERT_IMP(a_pos_bound, 1'b1, pos_r <= POS_W'(FRAME_BYTES), "frame position out of range")
  `EMFP_ASSERT_IMP(a_hdr_err, q_push && q_data.op == CMD_FRAME && !hdr_ok_r, q_data.err == ERR_HEADER, "bad header not flagged")

endmodule

`default_nettype wire

/* design/emfp_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on emfp_pkg for the command type and depth.
`default_nettype none
`include "energy_meter_frame_parser_top_defines.svh"

module emfp_cmd_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  emfp_pkg::emfp_cmd_t   push_data,
  output logic                  full,
  input  wire                   pop,
  output logic                  pop_valid,
  output emfp_pkg::emfp_cmd_t   pop_data
);
  import emfp_pkg::*;

  emfp_cmd_t             slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + CMDQ_CNT_W'(1);
      2'b01:   count_nxt = count_r - CMDQ_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                  : wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                  : rd_ptr_r + CMDQ_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `EMFP_ASSERT_IMP(a_no_overflow, full, !push, "push into full command queue")
  `EMFP_ASSERT_IMP(a_no_underflow, !pop_valid, !pop, "pop from empty command queue")

endmodule

`default_nettype wire

/* design/emfp_back.sv */
// Back end: applies frame and clear commands to the stored fields and the
// pulse total, and holds the result beat. Depends on emfp_pkg.
`default_nettype none
`include "energy_meter_frame_parser_top_defines.svh"

module emfp_back #(
  parameter int ENERGY_BITS = 48
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_valid,
  input  emfp_pkg::emfp_cmd_t              q_data,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [emfp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [emfp_pkg::OUT_USER_W-1:0]  out_tuser
);
  import emfp_pkg::*;

  logic [23:0] cur_r, volt_r, fast_r, pwr_r, cnt_r, base_r;
  logic [15:0] freq_r;
  logic [7:0]  status_r;
  logic [ENERGY_BITS-1:0] total_r, total_nxt;
  logic [23:0] cur_nxt, volt_nxt, fast_nxt, pwr_nxt, cnt_nxt, base_nxt;
  logic [15:0] freq_nxt;
  logic [7:0]  status_nxt;
  logic [23:0] delta;
  logic [ENERGY_BITS+ENERGY_OUT_W-1:0] total_ext;
  logic        is_frame, commit;
  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  assign is_frame = (q_data.op == CMD_FRAME);
  assign commit   = is_frame && (q_data.err == ERR_OK);
  assign q_pop    = q_valid && (!is_frame || !out_valid_r || out_tready);
  assign delta    = q_data.cnt - base_r;
  assign total_ext = {{ENERGY_OUT_W{1'b0}}, total_nxt};

  always_comb begin
    cur_nxt    = cur_r;
    volt_nxt   = volt_r;
    fast_nxt   = fast_r;
    pwr_nxt    = pwr_r;
    cnt_nxt    = cnt_r;
    freq_nxt   = freq_r;
    status_nxt = status_r;
    base_nxt   = base_r;
    total_nxt  = total_r;
    if (q_pop) begin
      if (!is_frame) begin
        total_nxt = '0;
        base_nxt  = cnt_r;
      end else if (commit) begin
        cur_nxt    = q_data.cur;
        volt_nxt   = q_data.volt;
        fast_nxt   = q_data.fast;
        pwr_nxt    = q_data.pwr;
        cnt_nxt    = q_data.cnt;
        freq_nxt   = q_data.freq;
        status_nxt = q_data.status;
        base_nxt   = q_data.cnt;
        total_nxt  = total_r + ENERGY_BITS'(delta);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      volt_r      <= '0;
      fast_r      <= '0;
      pwr_r       <= '0;
      cnt_r       <= '0;
      freq_r      <= '0;
      status_r    <= '0;
      base_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      volt_r   <= volt_nxt;
      fast_r   <= fast_nxt;
      pwr_r    <= pwr_nxt;
      cnt_r    <= cnt_nxt;
      freq_r   <= freq_nxt;
      status_r <= status_nxt;
      base_r   <= base_nxt;
      total_r  <= total_nxt;
      if (q_pop && is_frame) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_frame) begin
      out_data_r <= {total_ext[ENERGY_OUT_W-1:0], status_nxt, freq_nxt, cnt_nxt,
                     pwr_nxt, fast_nxt, volt_nxt, cur_nxt};
      out_user_r <= {q_data.err, commit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `EMFP_ASSERT_NXT(a_good_frame_out, q_pop && commit, out_tvalid && out_tuser[0] && out_tuser[2:1] == ERR_OK, "good frame not reported as valid")

endmodule

`default_nettype wire

/* test/energy_meter_frame_parser_top_test.sv */
// Self-checking testbench for energy_meter_frame_parser_top: frame-level stimulus,
// a scoreboard class that predicts each reply result, and randomized idling.
// Depends on emfp_pkg and the energy_meter_frame_parser_top RTL.
module energy_meter_frame_parser_top_test;
  import emfp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         TOTAL_BITS  = 48;

  typedef struct packed {
    logic        valid;
    logic [1:0]  err;
    logic [23:0] cur;
    logic [23:0] volt;
    logic [23:0] fast;
    logic [23:0] pwr;
    logic [23:0] cnt;
    logic [15:0] freq;
    logic [7:0]  status;
    logic [TOTAL_BITS-1:0] energy;
  } meter_reading_t;

  class frame_scoreboard;
    logic [1:0]            address;
    int                    position;
    logic [7:0]            running;
    bit                    header_ok;
    logic [7:0]            captured [CAP_DEPTH];
    meter_reading_t        last_good;
    logic [23:0]           baseline;
    meter_reading_t        readings [$];
    int unsigned           fail_count;

    function new();
      address = 2'd0;
      position = FRAME_BYTES;
      running = 8'd0;
      header_ok = 1'b0;
      foreach (captured[i]) captured[i] = 8'd0;
      last_good = '0;
      baseline = 24'd0;
      fail_count = 0;
    endfunction

    function void set_address(logic [1:0] a);
      address = a;
    endfunction

    function int pending();
      return readings.size();
    endfunction

    function void commit_fields();
      logic [23:0] delta;
      last_good.cur    = {captured[2], captured[1], captured[0]};
      last_good.volt   = {captured[5], captured[4], captured[3]};
      last_good.fast   = {captured[8], captured[7], captured[6]};
      last_good.pwr    = {captured[11], captured[10], captured[9]};
      last_good.cnt    = {captured[14], captured[13], captured[12]};
      last_good.freq   = {captured[16], captured[15]};
      last_good.status = captured[18];
      delta = last_good.cnt - baseline;
      baseline = last_good.cnt;
      last_good.energy = last_good.energy + {{(TOTAL_BITS-24){1'b0}}, delta};
    endfunction

    function void note_input(logic [1:0] kind, logic [7:0] b);
      logic [1:0]     err;
      meter_reading_t r;
      case (kind)
        KIND_START: begin
          position = 0;
          running = READ_CMD_BASE | {6'd0, address};
          header_ok = 1'b0;
        end
        KIND_CLEAR: begin
          last_good.energy = '0;
          baseline = last_good.cnt;
        end
        KIND_BYTE: begin
          if (position < FRAME_BYTES - 1) begin
            if (position == 0) header_ok = (b == HEADER_BYTE);
            else if (position <= CAP_DEPTH) captured[position-1] = b;
            running = running + b;
            position++;
          end else if (position == FRAME_BYTES - 1) begin
            if (!header_ok) err = ERR_HEADER;
            else if (~running != b) err = ERR_CSUM;
            else err = ERR_OK;
            if (err == ERR_OK) commit_fields();
            r = last_good;
            r.valid = (err == ERR_OK);
            r.err = err;
            readings.push_back(r);
            position++;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      meter_reading_t r;
      if (readings.size() == 0) begin
        $error("result beat with no expected reading: tdata %0h tuser %0h", data, user);
        fail_count++;
      end else begin
        r = readings.pop_front();
        compare_field("valid_res", r.valid, user[0]);
        compare_field("error_code", r.err, user[2:1]);
        compare_field("current_rms", r.cur, data[23:0]);
        compare_field("voltage_rms", r.volt, data[47:24]);
        compare_field("current_fast_rms", r.fast, data[71:48]);
        compare_field("active_power", r.pwr, data[95:72]);
        compare_field("pulse_counter", r.cnt, data[119:96]);
        compare_field("line_frequency", r.freq, data[135:120]);
        compare_field("status_bits", r.status, data[143:136]);
        compare_field("energy_pulses", r.energy, data[191:144]);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_data = 2'd0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;
  logic [1:0]            in_tuser = 2'd0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  frame_scoreboard sb = new();
  logic [1:0]      cur_address = 2'd0;
  int              burst_left = 0;
  int              items_sent = 0;
  logic [15:0]     rx_cycle = 16'd0;
  logic [1:0]      rx_mode = 2'd0;

  energy_meter_frame_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rx_cycle[2:0] != 3'd5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, b);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] body [22], input logic [7:0] csum_flip);
    logic [7:0] csum;
    csum = READ_CMD_BASE | {6'd0, cur_address};
    send_beat(KIND_START, pick_byte());
    for (int i = 0; i < 22; i++) begin
      if ($urandom_range(0, 49) == 0) send_beat({1'b1, 1'($urandom_range(0, 1))}, pick_byte());
      send_beat(KIND_BYTE, body[i]);
      csum = csum + body[i];
    end
    send_beat(KIND_BYTE, ~csum ^ csum_flip);
  endtask

  task automatic random_frame(input bit bad_header, input bit bad_csum);
    logic [7:0] body [22];
    foreach (body[i]) body[i] = pick_byte();
    body[0] = HEADER_BYTE;
    if (bad_header) begin
      do body[0] = pick_byte(); while (body[0] == HEADER_BYTE);
    end
    send_frame(body, bad_csum ? 8'($urandom_range(1, 255)) : 8'h00);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_address(input logic [1:0] a);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_address = a;
    sb.set_address(a);
  endtask

  task automatic random_phase(input int goal);
    int sel;
    int n;
    while (items_sent < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) random_frame(1'b0, 1'b0);
      else if (sel < 68) random_frame(1'b0, 1'b1);
      else if (sel < 74) random_frame(1'b1, 1'b0);
      else if (sel < 77) random_frame(1'b1, 1'b1);
      else if (sel < 85) begin
        n = $urandom_range(0, 22);
        send_beat(KIND_START, pick_byte());
        for (int i = 0; i < n; i++)
          send_beat(KIND_BYTE, (i == 0 && $urandom_range(0, 1)) ? HEADER_BYTE : pick_byte());
      end else if (sel < 90) send_beat(KIND_CLEAR, pick_byte());
      else if (sel < 95) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_beat(KIND_BYTE, pick_byte());
      end else send_beat(KIND_UNUSED, pick_byte());
    end
    random_frame(1'b0, 1'b0);
  endtask

  initial begin
    logic [7:0] body [22];
    logic [1:0] phase_addr [4];
    phase_addr = '{2'd3, 2'd1, 2'd0, 2'd2};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drop: byte and unused kind before any start, clear with nothing stored
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_UNUSED, 8'h00);
    send_beat(KIND_CLEAR, 8'hFF);
    body = '{8'h55, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'h00,
             8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
             8'h00, 8'hFF};
    send_frame(body, 8'h00);
    wait_drained();

    foreach (phase_addr[p]) begin
      write_address(phase_addr[p]);
      random_phase(items_sent + 300);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/emfp_pkg.sv
design/emfp_front.sv
design/emfp_cmd_fifo.sv
design/emfp_back.sv
design/energy_meter_frame_parser_top.sv
test/energy_meter_frame_parser_top_test.sv
